// File: hw/rtl/nkl_pkg.sv
package nkl_pkg;

    localparam int MAX_LIGHTS = 256;
    localparam int IDX_W      = $clog2(MAX_LIGHTS);
    localparam int CNT_W      = $clog2(MAX_LIGHTS + 1);

    localparam int MAX_ACTIVE = 32;
    localparam int ACT_W      = 6;
    localparam int EMIT_W     = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;

    localparam int POS_W  = 24;
    localparam int DIFF_W = POS_W + 1;
    localparam int SQ_W   = 2 * POS_W;
    localparam int DIST_W = 52;
    localparam int WORD_W = 32;

    localparam logic [ACT_W-1:0] MAX_ACTIVE_RESET = ACT_W'(16);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CULL = 1'b1;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [WORD_W-1:0]       falloff;
        logic [WORD_W-1:0]       lumen;
    } light_word_t;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] distance;
        logic [IDX_W-1:0]  idx;
    } entry_t;

    typedef struct packed {
        logic   clear;
        logic   shift;
        entry_t cand;
    } cell_ctrl_t;

endpackage

// File: hw/rtl/nkl_light_ram.sv
module nkl_light_ram
(
    input  logic                        clk,
    input  logic                        we,
    input  logic [nkl_pkg::IDX_W-1:0]   waddr,
    input  nkl_pkg::light_word_t        wdata,
    input  logic [nkl_pkg::IDX_W-1:0]   raddr,
    output nkl_pkg::light_word_t        rdata
);

    nkl_pkg::light_word_t mem [nkl_pkg::MAX_LIGHTS];
    nkl_pkg::light_word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/nkl_dist_pipe.sv
module nkl_dist_pipe
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [nkl_pkg::IDX_W-1:0]          in_idx,
    input  nkl_pkg::light_word_t               in_light,
    input  logic signed [nkl_pkg::POS_W-1:0]   cam_x,
    input  logic signed [nkl_pkg::POS_W-1:0]   cam_y,
    input  logic signed [nkl_pkg::POS_W-1:0]   cam_z,
    output nkl_pkg::entry_t                    cand,
    output logic                               busy
);

    localparam int DW = nkl_pkg::DIFF_W;
    localparam int PW = 2 * nkl_pkg::DIFF_W;

    logic                            v1_reg, v2_reg, v3_reg, v4_reg;
    logic [nkl_pkg::IDX_W-1:0]       idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic signed [DW-1:0]            dx1_reg, dy1_reg, dz1_reg;
    logic signed [DW-1:0]            dy2_reg, dz2_reg, dz3_reg;
    logic [nkl_pkg::DIST_W-1:0]      acc2_reg, acc3_reg, dist4_reg;

    logic signed [DW-1:0]            dx_next, dy_next, dz_next;
    logic signed [PW-1:0]            px, py, pz;
    logic [nkl_pkg::DIST_W-1:0]      sqx, sqy, sqz;

    always_comb
    begin
        dx_next = $signed({in_light.x[nkl_pkg::POS_W-1], in_light.x})
                - $signed({cam_x[nkl_pkg::POS_W-1], cam_x});
        dy_next = $signed({in_light.y[nkl_pkg::POS_W-1], in_light.y})
                - $signed({cam_y[nkl_pkg::POS_W-1], cam_y});
        dz_next = $signed({in_light.z[nkl_pkg::POS_W-1], in_light.z})
                - $signed({cam_z[nkl_pkg::POS_W-1], cam_z});
        px  = dx1_reg * dx1_reg;
        py  = dy2_reg * dy2_reg;
        pz  = dz3_reg * dz3_reg;
        sqx = {{(nkl_pkg::DIST_W - nkl_pkg::SQ_W){1'b0}}, px[nkl_pkg::SQ_W-1:0]};
        sqy = {{(nkl_pkg::DIST_W - nkl_pkg::SQ_W){1'b0}}, py[nkl_pkg::SQ_W-1:0]};
        sqz = {{(nkl_pkg::DIST_W - nkl_pkg::SQ_W){1'b0}}, pz[nkl_pkg::SQ_W-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg  <= in_idx;
        dx1_reg   <= dx_next;
        dy1_reg   <= dy_next;
        dz1_reg   <= dz_next;

        idx2_reg  <= idx1_reg;
        acc2_reg  <= sqx;
        dy2_reg   <= dy1_reg;
        dz2_reg   <= dz1_reg;

        idx3_reg  <= idx2_reg;
        acc3_reg  <= acc2_reg + sqy;
        dz3_reg   <= dz2_reg;

        idx4_reg  <= idx3_reg;
        dist4_reg <= acc3_reg + sqz;
    end

    assign cand = '{valid: v4_reg, distance: dist4_reg, idx: idx4_reg};
    assign busy = v1_reg | v2_reg | v3_reg | v4_reg;

endmodule

// File: hw/rtl/nkl_cell.sv
module nkl_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  nkl_pkg::cell_ctrl_t   ctrl,
    input  logic                  en,
    input  nkl_pkg::entry_t       prev_q,
    input  logic                  prev_ins,
    input  nkl_pkg::entry_t       next_q,
    output nkl_pkg::entry_t       q,
    output logic                  ins
);

    logic                           valid_reg, valid_next;
    logic [nkl_pkg::DIST_W-1:0]     dist_reg, dist_next;
    logic [nkl_pkg::IDX_W-1:0]      idx_reg, idx_next;

    always_comb
    begin
        ins = ctrl.cand.valid && en && (!valid_reg || (ctrl.cand.distance < dist_reg));
        valid_next = valid_reg;
        dist_next  = dist_reg;
        idx_next   = idx_reg;
        priority if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_next = next_q.valid;
            dist_next  = next_q.distance;
            idx_next   = next_q.idx;
        end
        else if (ins)
        begin
            if (prev_ins)
            begin
                valid_next = prev_q.valid;
                dist_next  = prev_q.distance;
                idx_next   = prev_q.idx;
            end
            else
            begin
                valid_next = 1'b1;
                dist_next  = ctrl.cand.distance;
                idx_next   = ctrl.cand.idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        idx_reg  <= idx_next;
    end

    assign q = '{valid: valid_reg, distance: dist_reg, idx: idx_reg};

endmodule

// File: hw/rtl/nearest_k_light_selector.sv
// Load items store one light each in a 256-entry table until it is full; the block
// stays ready after a load. A cull walks the n stored lights one per cycle through the
// single table read port and a four-stage squared-distance pipeline into a sorted row of
// 32 cells, then shifts the row out nearest first, one result per cycle. A cull keeps
// busy high through its walk, drain and emit states, and its results follow as one
// unbroken burst of k consecutive strobes, k being the number of results, the last
// marked by last and shown in the first cycle after busy falls. The receiver cannot
// stall, so it must take one result in every cycle of the burst. Equal distances come
// out in table order. A cull with an empty table or a zero limit returns no results;
// a limit above 32 acts as 32.
module nearest_k_light_selector
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                start,
    output logic                                busy,
    input  logic                                operation,
    input  logic                                first_light,
    input  logic signed [nkl_pkg::POS_W-1:0]    light_x,
    input  logic signed [nkl_pkg::POS_W-1:0]    light_y,
    input  logic signed [nkl_pkg::POS_W-1:0]    light_z,
    input  logic [nkl_pkg::WORD_W-1:0]          falloff_word,
    input  logic [nkl_pkg::WORD_W-1:0]          lumen_word,
    input  logic signed [nkl_pkg::POS_W-1:0]    camera_x,
    input  logic signed [nkl_pkg::POS_W-1:0]    camera_y,
    input  logic signed [nkl_pkg::POS_W-1:0]    camera_z,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nkl_pkg::ACT_W-1:0]           cfg_data,

    output logic                                result_valid,
    output logic [nkl_pkg::IDX_W-1:0]           light_index,
    output logic signed [nkl_pkg::POS_W-1:0]    out_x,
    output logic signed [nkl_pkg::POS_W-1:0]    out_y,
    output logic signed [nkl_pkg::POS_W-1:0]    out_z,
    output logic [nkl_pkg::WORD_W-1:0]          out_falloff,
    output logic [nkl_pkg::WORD_W-1:0]          out_lumen,
    output logic [nkl_pkg::ACT_W-1:0]           active_count,
    output logic                                last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam int N = nkl_pkg::MAX_ACTIVE;

    logic [1:0]                         state_reg, state_next;
    logic [nkl_pkg::CNT_W-1:0]          stored_count_reg, stored_count_next;
    logic [nkl_pkg::ACT_W-1:0]          max_active_reg;
    logic [nkl_pkg::ACT_W-1:0]          limit_reg, limit_next;
    logic [nkl_pkg::ACT_W-1:0]          kept_reg, kept_next;
    logic [nkl_pkg::IDX_W-1:0]          last_idx_reg, last_idx_next;
    logic [nkl_pkg::IDX_W-1:0]          walk_cnt_reg, walk_cnt_next;
    logic [nkl_pkg::EMIT_W-1:0]         emit_cnt_reg, emit_cnt_next;
    logic                               rd_valid_reg;
    logic [nkl_pkg::IDX_W-1:0]          rd_idx_reg;
    logic signed [nkl_pkg::POS_W-1:0]   cam_x_reg, cam_y_reg, cam_z_reg;
    logic                               out_valid_reg;
    logic [nkl_pkg::IDX_W-1:0]          out_idx_reg;
    logic [nkl_pkg::ACT_W-1:0]          out_count_reg;
    logic                               out_last_reg;

    logic                               accept, accept_load, accept_cull;
    logic                               emit_last;
    logic [nkl_pkg::ACT_W-1:0]          limit_cfg;
    logic                               ram_we;
    logic [nkl_pkg::IDX_W-1:0]          ram_waddr, ram_raddr;
    nkl_pkg::light_word_t               ram_wdata, ram_rdata;
    nkl_pkg::entry_t                    cand;
    logic                               pipe_busy;
    nkl_pkg::cell_ctrl_t                cell_ctrl;
    nkl_pkg::entry_t                    cell_q [N];
    logic                               cell_ins [N];

    assign accept      = start && !busy;
    assign accept_load = accept && (operation == nkl_pkg::OP_LOAD);
    assign accept_cull = accept && (operation == nkl_pkg::OP_CULL);
    assign busy        = (state_reg != ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign emit_last   = (emit_cnt_reg == nkl_pkg::EMIT_W'(kept_reg - nkl_pkg::ACT_W'(1)));

    always_comb
    begin
        limit_cfg = (max_active_reg > nkl_pkg::ACT_W'(N)) ? nkl_pkg::ACT_W'(N)
                                                          : max_active_reg;
        ram_we    = accept_load
                 && (first_light
                 || (stored_count_reg < nkl_pkg::CNT_W'(nkl_pkg::MAX_LIGHTS)));
        ram_waddr = first_light ? '0 : nkl_pkg::IDX_W'(stored_count_reg);
        ram_wdata = '{x: light_x, y: light_y, z: light_z,
                      falloff: falloff_word, lumen: lumen_word};
        ram_raddr = (state_reg == ST_EMIT) ? cell_q[0].idx : walk_cnt_reg;

        stored_count_next = stored_count_reg;
        if (ram_we)
        begin
            stored_count_next = first_light ? nkl_pkg::CNT_W'(1)
                                            : stored_count_reg + nkl_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        limit_next    = limit_reg;
        kept_next     = kept_reg;
        last_idx_next = last_idx_reg;
        walk_cnt_next = walk_cnt_reg;
        emit_cnt_next = emit_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_cull)
                begin
                    limit_next    = limit_cfg;
                    kept_next     = (nkl_pkg::CNT_W'(limit_cfg) > stored_count_reg)
                                  ? nkl_pkg::ACT_W'(stored_count_reg) : limit_cfg;
                    last_idx_next = nkl_pkg::IDX_W'(stored_count_reg
                                                    - nkl_pkg::CNT_W'(1));
                    walk_cnt_next = '0;
                    if ((stored_count_reg != '0) && (limit_cfg != '0))
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                walk_cnt_next = walk_cnt_reg + nkl_pkg::IDX_W'(1);
                if (walk_cnt_reg == last_idx_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                emit_cnt_next = '0;
                if (!rd_valid_reg && !pipe_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                emit_cnt_next = emit_cnt_reg + nkl_pkg::EMIT_W'(1);
                if (emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            stored_count_reg <= '0;
            max_active_reg   <= nkl_pkg::MAX_ACTIVE_RESET;
            rd_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            stored_count_reg <= stored_count_next;
            rd_valid_reg     <= (state_reg == ST_WALK);
            out_valid_reg    <= (state_reg == ST_EMIT);
            if (cfg_valid && cfg_ready)
            begin
                max_active_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg     <= limit_next;
        kept_reg      <= kept_next;
        last_idx_reg  <= last_idx_next;
        walk_cnt_reg  <= walk_cnt_next;
        emit_cnt_reg  <= emit_cnt_next;
        rd_idx_reg    <= walk_cnt_reg;
        out_idx_reg   <= cell_q[0].idx;
        out_count_reg <= kept_reg;
        out_last_reg  <= emit_last;
        if (accept_cull)
        begin
            cam_x_reg <= camera_x;
            cam_y_reg <= camera_y;
            cam_z_reg <= camera_z;
        end
    end

    nkl_light_ram u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    nkl_dist_pipe u_dist
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rd_valid_reg),
        .in_idx   (rd_idx_reg),
        .in_light (ram_rdata),
        .cam_x    (cam_x_reg),
        .cam_y    (cam_y_reg),
        .cam_z    (cam_z_reg),
        .cand     (cand),
        .busy     (pipe_busy)
    );

    assign cell_ctrl = '{clear: accept_cull, shift: (state_reg == ST_EMIT), cand: cand};

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        nkl_pkg::entry_t prev_q, next_q;
        logic            prev_ins;
        logic            en;

        assign en = (nkl_pkg::ACT_W'(k) < limit_reg);

        if (k == 0)
        begin : g_first
            assign prev_q   = '0;
            assign prev_ins = 1'b0;
        end
        else
        begin : g_mid
            assign prev_q   = cell_q[k-1];
            assign prev_ins = cell_ins[k-1];
        end

        if (k == N - 1)
        begin : g_end
            assign next_q = '0;
        end
        else
        begin : g_inner
            assign next_q = cell_q[k+1];
        end

        nkl_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .en       (en),
            .prev_q   (prev_q),
            .prev_ins (prev_ins),
            .next_q   (next_q),
            .q        (cell_q[k]),
            .ins      (cell_ins[k])
        );
    end

    assign result_valid = out_valid_reg;
    assign light_index  = out_idx_reg;
    assign out_x        = ram_rdata.x;
    assign out_y        = ram_rdata.y;
    assign out_z        = ram_rdata.z;
    assign out_falloff  = ram_rdata.falloff;
    assign out_lumen    = ram_rdata.lumen;
    assign active_count = out_count_reg;
    assign last         = out_last_reg;

endmodule

// File: hw/rtl/nkl_checker.sv
module nkl_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                operation,
    input  logic                                result_valid,
    input  logic [nkl_pkg::ACT_W-1:0]           active_count,
    input  logic                                last
);

    // A burst of results has no gaps and ends only with the last transfer.
    a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> result_valid)
        else $error("result burst broken before last");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (active_count != '0)
                      && (active_count <= nkl_pkg::ACT_W'(nkl_pkg::MAX_ACTIVE)))
        else $error("active_count out of range");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> $stable(active_count))
        else $error("active_count changed within a burst");

    a_busy_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("block idle while results remain");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (operation == nkl_pkg::OP_LOAD) |=> !result_valid)
        else $error("result after a load transfer");

endmodule

bind nearest_k_light_selector nkl_checker u_nkl_checker (.*);
